// ===== rtl/hbmp_pkg.sv =====
package hbmp_pkg;

	localparam int unsigned RowBits      = 10;
	localparam int unsigned ColBits      = 10;
	localparam int unsigned HeightBits   = 32;
	localparam int unsigned CountBits    = 13;
	localparam int unsigned ShiftBits    = 3;
	localparam int unsigned ThreshBits   = 13;
	localparam int unsigned DimBits      = 11;
	localparam int unsigned CfgIndexBits = 2;
	localparam int unsigned CfgDataBits  = 13;

	localparam int unsigned MaxColsDefault  = 1024;
	localparam int unsigned MaxShiftDefault = 6;

	localparam logic [CountBits-1:0]  CountMax  = '1;
	localparam logic [ThreshBits-1:0] ThreshMax = 13'd4096;
	localparam logic [HeightBits-1:0] HeightMin = {1'b1, {(HeightBits-1){1'b0}}};

	localparam logic [ShiftBits-1:0]  ShiftReset  = 3'd1;
	localparam logic [ThreshBits-1:0] ThreshReset = 13'd4;
	localparam logic [DimBits-1:0]    RowsReset   = 11'd1024;
	localparam logic [DimBits-1:0]    ColsReset   = 11'd1024;

	typedef enum logic [CfgIndexBits-1:0] {
		CFG_BLOCK_SHIFT      = 2'd0,
		CFG_CLOSED_THRESHOLD = 2'd1,
		CFG_MAP_ROWS         = 2'd2,
		CFG_MAP_COLS         = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [RowBits-1:0]           cell_row;
		logic [ColBits-1:0]           cell_col;
		logic signed [HeightBits-1:0] cell_height;
		logic                         cell_closed;
	} cell_t;

	typedef struct packed {
		logic [RowBits-1:0]           block_row;
		logic [ColBits-1:0]           block_col;
		logic signed [HeightBits-1:0] open_max;
		logic signed [HeightBits-1:0] all_max;
		logic                         block_closed;
	} block_t;

	typedef struct packed {
		logic signed [HeightBits-1:0] all_max;
		logic signed [HeightBits-1:0] open_max;
		logic [CountBits-1:0]         closed_count;
	} acc_t;

endpackage

// ===== rtl/hbmp_stream_if.sv =====
interface hbmp_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/hbmp_ram.sv =====
module hbmp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AddrBits-1:0] waddr,
	input  logic [WIDTH-1:0]    wdata,
	input  logic                re,
	input  logic [AddrBits-1:0] raddr,
	output logic [WIDTH-1:0]    rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/height_block_max_pool_closed_count_top.sv =====
// Pools a raster stream of fine height cells into square blocks of side 2^block_shift and
// emits one item per whole block when its far-corner cell arrives: block coordinates, the
// maximum height, the maximum over open cells (most negative if none is open) and a closed
// flag (closed count at or above closed_threshold). Cells outside whole blocks give no
// item. One cell is taken every cycle while the output buffer has room. The per-column
// accumulators live in one MAX_COLS-deep memory with a registered read, updated by
// read-modify-write with a forward path for back-to-back cells of the same block column;
// no clearing pass is needed, since every block starts at its first cell. Block items are
// formed in stage 1 and queued in a four-item output buffer that keeps the input flowing.
module height_block_max_pool_closed_count_top #(
	parameter int unsigned MAX_COLS  = hbmp_pkg::MaxColsDefault,
	parameter int unsigned MAX_SHIFT = hbmp_pkg::MaxShiftDefault
) (
	input  logic                               clk,
	input  logic                               arst_n,
	hbmp_stream_if.sink                        cells,
	hbmp_stream_if.source                      blocks,
	input  logic                               cfg_we,
	input  logic [hbmp_pkg::CfgIndexBits-1:0]  cfg_index,
	input  logic [hbmp_pkg::CfgDataBits-1:0]   cfg_data
);

	localparam int unsigned AddrBits  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int unsigned AccBits   = $bits(hbmp_pkg::acc_t);
	localparam int unsigned BufDepth  = 4;
	localparam int unsigned PtrBits   = $clog2(BufDepth);
	localparam int unsigned CntBits   = PtrBits + 1;

	logic [hbmp_pkg::ShiftBits-1:0]  shift_q;
	logic [hbmp_pkg::ThreshBits-1:0] thresh_q;
	logic [hbmp_pkg::DimBits-1:0]    rows_q;
	logic [hbmp_pkg::DimBits-1:0]    cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= hbmp_pkg::ShiftReset;
			thresh_q <= hbmp_pkg::ThreshReset;
			rows_q   <= hbmp_pkg::RowsReset;
			cols_q   <= hbmp_pkg::ColsReset;
		end else if (cfg_we) begin
			unique case (hbmp_pkg::cfg_index_t'(cfg_index))
				hbmp_pkg::CFG_BLOCK_SHIFT: begin
					if (32'(cfg_data[hbmp_pkg::ShiftBits-1:0]) > MAX_SHIFT) begin
						shift_q <= hbmp_pkg::ShiftBits'(MAX_SHIFT);
					end else begin
						shift_q <= cfg_data[hbmp_pkg::ShiftBits-1:0];
					end
				end
				hbmp_pkg::CFG_CLOSED_THRESHOLD: begin
					if (cfg_data[hbmp_pkg::ThreshBits-1:0] > hbmp_pkg::ThreshMax) begin
						thresh_q <= hbmp_pkg::ThreshMax;
					end else begin
						thresh_q <= cfg_data[hbmp_pkg::ThreshBits-1:0];
					end
				end
				hbmp_pkg::CFG_MAP_ROWS: begin
					rows_q <= cfg_data[hbmp_pkg::DimBits-1:0];
				end
				hbmp_pkg::CFG_MAP_COLS: begin
					cols_q <= cfg_data[hbmp_pkg::DimBits-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// stage 0: classify the cell and issue the accumulator read
	hbmp_pkg::cell_t               cell_in;
	logic                          accept;
	logic [hbmp_pkg::RowBits-1:0]  row_low;
	logic [hbmp_pkg::ColBits-1:0]  col_low;
	logic [hbmp_pkg::DimBits-1:0]  row_lim;
	logic [hbmp_pkg::DimBits-1:0]  col_lim;
	logic [hbmp_pkg::RowBits-1:0]  brow;
	logic [hbmp_pkg::ColBits-1:0]  bcol;
	logic                          in_range;
	logic                          first_cell;
	logic                          last_cell;
	logic [AddrBits-1:0]           rd_addr;

	assign cell_in = cells.payload;
	assign accept  = cells.valid && cells.ready;

	always_comb begin
		row_low    = (hbmp_pkg::RowBits'(1) << shift_q) - hbmp_pkg::RowBits'(1);
		col_low    = (hbmp_pkg::ColBits'(1) << shift_q) - hbmp_pkg::ColBits'(1);
		row_lim    = (rows_q >> shift_q) << shift_q;
		col_lim    = (cols_q >> shift_q) << shift_q;
		brow       = cell_in.cell_row >> shift_q;
		bcol       = cell_in.cell_col >> shift_q;
		in_range   = ({1'b0, cell_in.cell_row} < row_lim)
			&& ({1'b0, cell_in.cell_col} < col_lim)
			&& (32'(bcol) < MAX_COLS);
		first_cell = ((cell_in.cell_row & row_low) == '0)
			&& ((cell_in.cell_col & col_low) == '0);
		last_cell  = ((cell_in.cell_row & row_low) == row_low)
			&& ((cell_in.cell_col & col_low) == col_low);
		rd_addr    = AddrBits'(bcol);
	end

	logic                                 valid_s1;
	logic                                 first_s1;
	logic                                 last_s1;
	logic                                 closed_s1;
	logic signed [hbmp_pkg::HeightBits-1:0] height_s1;
	logic [AddrBits-1:0]                  addr_s1;
	logic [hbmp_pkg::RowBits-1:0]         brow_s1;
	logic [hbmp_pkg::ColBits-1:0]         bcol_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_s1  <= first_cell;
			last_s1   <= last_cell;
			closed_s1 <= cell_in.cell_closed;
			height_s1 <= cell_in.cell_height;
			addr_s1   <= rd_addr;
			brow_s1   <= brow;
			bcol_s1   <= bcol;
		end
	end

	// stage 1: modify and write back
	logic [AccBits-1:0]   rd_data;
	hbmp_pkg::acc_t       acc_old;
	hbmp_pkg::acc_t       acc_new;
	logic                 fwd_valid_q;
	logic [AddrBits-1:0]  fwd_addr_q;
	hbmp_pkg::acc_t       fwd_data_q;
	hbmp_pkg::block_t     result;

	hbmp_ram #(
		.WIDTH (AccBits),
		.DEPTH (MAX_COLS)
	) u_acc_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (addr_s1),
		.wdata (acc_new),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_comb begin
		if (fwd_valid_q && (fwd_addr_q == addr_s1)) begin
			acc_old = fwd_data_q;
		end else begin
			acc_old = hbmp_pkg::acc_t'(rd_data);
		end
		if (first_s1) begin
			acc_new.all_max      = height_s1;
			acc_new.open_max     = closed_s1 ? hbmp_pkg::HeightMin : height_s1;
			acc_new.closed_count = closed_s1 ? hbmp_pkg::CountBits'(1) : '0;
		end else begin
			acc_new = acc_old;
			if (height_s1 > acc_old.all_max) begin
				acc_new.all_max = height_s1;
			end
			if (closed_s1) begin
				if (acc_old.closed_count != hbmp_pkg::CountMax) begin
					acc_new.closed_count = acc_old.closed_count + hbmp_pkg::CountBits'(1);
				end
			end else if (height_s1 > acc_old.open_max) begin
				acc_new.open_max = height_s1;
			end
		end
		result.block_row    = brow_s1;
		result.block_col    = bcol_s1;
		result.open_max     = acc_new.open_max;
		result.all_max      = acc_new.all_max;
		result.block_closed = acc_new.closed_count >= thresh_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= acc_new;
		end
	end

	// output buffer
	hbmp_pkg::block_t     buf_q [BufDepth];
	logic [PtrBits-1:0]   wr_ptr_q;
	logic [PtrBits-1:0]   rd_ptr_q;
	logic [CntBits-1:0]   cnt_q;
	logic                 push;
	logic                 pop;
	logic [CntBits-1:0]   pending;

	assign push    = valid_s1 && last_s1;
	assign pop     = blocks.valid && blocks.ready;
	assign pending = cnt_q + CntBits'(push);

	assign cells.ready    = pending < CntBits'(BufDepth);
	assign blocks.valid   = cnt_q != '0;
	assign blocks.payload = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrBits'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrBits'(1);
			end
			cnt_q <= cnt_q + CntBits'(push) - CntBits'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= result;
		end
	end

	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntBits'(BufDepth))
		else $error("output buffer count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (cnt_q != CntBits'(BufDepth)))
		else $error("output buffer overflow");

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (cnt_q != '0))
		else $error("block item lost");

	a_fwd_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_valid_q |-> $past(valid_s1))
		else $error("forward path without write");

endmodule

// ===== test/hbmp_pool_checker.sv =====
`timescale 1ns / 1ps

module hbmp_pool_checker
	import hbmp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cell_valid,
	input  logic                    cell_ready,
	input  cell_t                   cell_in,
	input  logic                    block_valid,
	input  logic                    block_ready,
	input  block_t                  block,
	input  logic                    cfg_we,
	input  logic [CfgIndexBits-1:0] cfg_index,
	input  logic [CfgDataBits-1:0]  cfg_data,
	output int                      mismatches,
	output int                      waiting
);

	logic [ShiftBits-1:0]  pool_shift;
	logic [ThreshBits-1:0] pool_thresh;
	logic [DimBits-1:0]    pool_rows;
	logic [DimBits-1:0]    pool_cols;

	logic signed [HeightBits-1:0] col_all_max [MaxColsDefault];
	logic signed [HeightBits-1:0] col_open_max [MaxColsDefault];
	logic [CountBits-1:0]         col_closed [MaxColsDefault];

	block_t pending_blocks [$];

	task automatic pool_cell(input cell_t c);
		logic [RowBits-1:0]           low;
		logic [DimBits-1:0]           row_lim;
		logic [DimBits-1:0]           col_lim;
		logic [ColBits-1:0]           k;
		logic signed [HeightBits-1:0] h;
		block_t                       b;
		low = (10'd1 << pool_shift) - 10'd1;
		row_lim = (pool_rows >> pool_shift) << pool_shift;
		col_lim = (pool_cols >> pool_shift) << pool_shift;
		if ({1'b0, c.cell_row} >= row_lim || {1'b0, c.cell_col} >= col_lim)
			return;
		k = c.cell_col >> pool_shift;
		h = c.cell_height;
		if ((c.cell_row & low) == '0 && (c.cell_col & low) == '0) begin
			col_all_max[k] = h;
			col_open_max[k] = c.cell_closed ? HeightMin : h;
			col_closed[k] = c.cell_closed ? 13'd1 : 13'd0;
		end else begin
			if (h > col_all_max[k])
				col_all_max[k] = h;
			if (c.cell_closed) begin
				if (col_closed[k] != CountMax)
					col_closed[k] = col_closed[k] + 13'd1;
			end else if (h > col_open_max[k]) begin
				col_open_max[k] = h;
			end
		end
		if ((c.cell_row & low) != low || (c.cell_col & low) != low)
			return;
		b.block_row = c.cell_row >> pool_shift;
		b.block_col = k;
		b.open_max = col_open_max[k];
		b.all_max = col_all_max[k];
		b.block_closed = col_closed[k] >= pool_thresh;
		pending_blocks = {pending_blocks, b};
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t %s expected %h actual %h", $time, what, want, got);
		end
	endtask

	always @(negedge clk or negedge arst_n) begin
		block_t want;
		if (!arst_n) begin
			pool_shift = ShiftReset;
			pool_thresh = ThreshReset;
			pool_rows = RowsReset;
			pool_cols = ColsReset;
			pending_blocks.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BLOCK_SHIFT: begin
						pool_shift = (cfg_data[ShiftBits-1:0] > MaxShiftDefault) ?
							ShiftBits'(MaxShiftDefault) : cfg_data[ShiftBits-1:0];
					end
					CFG_CLOSED_THRESHOLD: begin
						pool_thresh = (cfg_data > ThreshMax) ? ThreshMax : cfg_data;
					end
					CFG_MAP_ROWS: begin
						pool_rows = cfg_data[DimBits-1:0];
					end
					CFG_MAP_COLS: begin
						pool_cols = cfg_data[DimBits-1:0];
					end
					default: begin
					end
				endcase
			end
			if (block_valid && block_ready) begin
				if (pending_blocks.size() == 0) begin
					mismatches++;
					$display("%0t block item expected none actual %h", $time, block);
				end else begin
					want = pending_blocks.pop_front();
					check_field("block_row", want.block_row, block.block_row);
					check_field("block_col", want.block_col, block.block_col);
					check_field("open_max", want.open_max, block.open_max);
					check_field("all_max", want.all_max, block.all_max);
					check_field("block_closed", want.block_closed, block.block_closed);
				end
			end
			if (cell_valid && cell_ready)
				pool_cell(cell_in);
		end
		waiting = pending_blocks.size();
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import hbmp_pkg::*;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we;
	logic [CfgIndexBits-1:0] cfg_index;
	logic [CfgDataBits-1:0]  cfg_data;
	int                      mismatches;
	int                      waiting;

	hbmp_stream_if #(.payload_t(cell_t))  cells ();
	hbmp_stream_if #(.payload_t(block_t)) blocks ();

	logic [ShiftBits-1:0] cur_shift = ShiftReset;
	logic [DimBits-1:0]   cur_rows = RowsReset;
	logic [DimBits-1:0]   cur_cols = ColsReset;
	bit                   cols_seen [MaxColsDefault];
	int                   live_cells;
	bit                   steady_tx;
	bit                   steady_rx;
	bit                   hold_req;

	height_block_max_pool_closed_count_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cells    (cells),
		.blocks   (blocks),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	hbmp_pool_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cells.valid),
		.cell_ready (cells.ready),
		.cell_in    (cells.payload),
		.block_valid(blocks.valid),
		.block_ready(blocks.ready),
		.block      (blocks.payload),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.waiting    (waiting)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int idle_len();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
	endfunction

	function automatic logic [HeightBits-1:0] rand_height();
		case ($urandom_range(0, 7))
			0: return HeightMin;
			1: return 32'h7fff_ffff;
			2, 3: return $unsigned($signed($urandom_range(0, 200)) - 100);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_cell(input logic [RowBits-1:0] row, input logic [ColBits-1:0] col,
			input logic [HeightBits-1:0] h, input logic closed);
		logic [RowBits-1:0] low;
		logic [DimBits-1:0] row_lim;
		logic [DimBits-1:0] col_lim;
		logic [ColBits-1:0] k;
		bit                 took;
		int                 gap;
		low = (10'd1 << cur_shift) - 10'd1;
		row_lim = (cur_rows >> cur_shift) << cur_shift;
		col_lim = (cur_cols >> cur_shift) << cur_shift;
		if ({1'b0, row} < row_lim && {1'b0, col} < col_lim) begin
			k = col >> cur_shift;
			// move to the block's first cell if its column entry holds nothing yet
			if (!cols_seen[k] && ((row & low) != '0 || (col & low) != '0)) begin
				row = row & ~low;
				col = col & ~low;
			end
			cols_seen[k] = 1'b1;
			live_cells++;
		end
		gap = (!steady_tx && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		if (gap > 0) begin
			cells.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cells.valid <= 1'b1;
		cells.payload <= '{cell_row: row, cell_col: col, cell_height: h, cell_closed: closed};
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = cells.ready;
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CfgDataBits-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic configure(input logic [CfgDataBits-1:0] shift_v,
			input logic [CfgDataBits-1:0] thr_v, input logic [CfgDataBits-1:0] rows_v,
			input logic [CfgDataBits-1:0] cols_v);
		cells.valid <= 1'b0;
		while (waiting != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		write_reg(CFG_BLOCK_SHIFT, shift_v);
		write_reg(CFG_CLOSED_THRESHOLD, thr_v);
		write_reg(CFG_MAP_ROWS, rows_v);
		write_reg(CFG_MAP_COLS, cols_v);
		cfg_we <= 1'b0;
		cur_shift = (shift_v[ShiftBits-1:0] > MaxShiftDefault) ?
			ShiftBits'(MaxShiftDefault) : shift_v[ShiftBits-1:0];
		cur_rows = rows_v[DimBits-1:0];
		cur_cols = cols_v[DimBits-1:0];
	endtask

	task automatic sweep(input int r0, input int c0, input int nr, input int nc,
			input int closed_pct, input int flaw_pct);
		int roll;
		for (int r = 0; r < nr; r++) begin
			for (int c = 0; c < nc; c++) begin
				roll = $urandom_range(0, 99);
				if (roll < flaw_pct)
					send_cell(RowBits'($urandom_range(0, 1023)),
						ColBits'($urandom_range(0, 1023)), rand_height(),
						1'($urandom_range(0, 1)));
				if (roll >= flaw_pct / 2)
					send_cell(RowBits'(r0 + r), ColBits'(c0 + c), rand_height(),
						$urandom_range(0, 99) < closed_pct);
			end
		end
	endtask

	initial begin
		blocks.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				blocks.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				if ($urandom_range(0, 15) == 0)
					steady_rx = !steady_rx;
				blocks.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				if (!steady_rx) begin
					blocks.ready <= 1'b0;
					repeat (idle_len()) @(posedge clk);
				end
			end
		end
	end

	initial begin
		int phase;
		int sh;
		int nr;
		int nc;
		int rows_v;
		int cols_v;
		int thr_v;
		int r0;
		int c0;
		int pick;
		int flaw;
		cells.valid = 1'b0;
		cells.payload = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_BLOCK_SHIFT;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 2x2 blocks, threshold 4
		send_cell(0, 0, 32'h7fff_ffff, 1'b1);
		send_cell(0, 1, 32'h8000_0000, 1'b1);
		send_cell(1, 0, 32'h0000_0000, 1'b1);
		send_cell(1, 1, 32'hffff_ffff, 1'b1);
		send_cell(1022, 1022, -32'sd5, 1'b0);
		send_cell(1022, 1023, 32'h8000_0000, 1'b0);
		send_cell(1023, 1022, 32'd123, 1'b1);
		send_cell(1023, 1023, -32'sd7, 1'b0);
		// single-cell blocks, zero threshold
		configure(0, 0, 1024, 1024);
		send_cell(5, 7, 32'd100, 1'b0);
		send_cell(1023, 0, 32'hffff_ffff, 1'b1);
		// partial edge blocks
		configure(1, 2, 3, 5);
		send_cell(2, 0, 32'd1, 1'b0);
		send_cell(0, 4, 32'd2, 1'b1);
		send_cell(0, 2, 32'd10, 1'b1);
		send_cell(0, 3, 32'd20, 1'b0);
		send_cell(1, 2, 32'd30, 1'b1);
		send_cell(1, 3, -32'sd40, 1'b0);
		// oversized shift: far corner of a 64x64 block
		configure(7, 4096, 64, 64);
		send_cell(0, 0, 32'd9, 1'b1);
		send_cell(63, 63, -32'sd3, 1'b1);

		live_cells = 0;
		phase = 0;
		while (live_cells < 400) begin
			if (phase == 0) begin
				sh = 0;
				nr = 8;
				nc = 8;
				rows_v = 1024;
				cols_v = 1024;
			end else begin
				pick = $urandom_range(0, 9);
				sh = (pick < 3) ? 1 : (pick < 6) ? 2 : (pick < 8) ? 0 : 3;
				nr = ((sh == 3) ? 1 : $urandom_range(1, 3)) * (1 << sh) + $urandom_range(0, 1);
				nc = ((sh == 3) ? 1 : $urandom_range(1, 3)) * (1 << sh) + $urandom_range(0, 1);
				pick = $urandom_range(0, 4);
				rows_v = (pick == 0) ? 1024 : (pick == 1) ? 2047 : $urandom_range(1, nr + 1);
				pick = $urandom_range(0, 4);
				cols_v = (pick == 0) ? 1024 : (pick == 1) ? 2047 : $urandom_range(1, nc + 1);
			end
			pick = $urandom_range(0, 9);
			thr_v = (pick == 0) ? 0 : (pick == 1) ? 8191 : (pick == 2) ? 4096 :
				$urandom_range(0, (1 << (2 * sh)) + 1);
			r0 = (rows_v >= 1024) ? (($urandom_range(0, 1023 - nr) >> sh) << sh) : 0;
			c0 = (cols_v >= 1024) ? (($urandom_range(0, 1023 - nc) >> sh) << sh) : 0;
			flaw = (phase > 0 && $urandom_range(0, 9) < 3) ? 8 : 0;
			configure(CfgDataBits'(sh), CfgDataBits'(thr_v), CfgDataBits'(rows_v),
				CfgDataBits'(cols_v));
			steady_tx = ($urandom_range(0, 3) == 0);
			if (phase == 0) begin
				steady_tx = 1'b1;
				hold_req = 1'b1;
			end
			sweep(r0, c0, nr, nc, $urandom_range(0, 100), flaw);
			phase++;
		end

		cells.valid <= 1'b0;
		while (waiting != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && waiting == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
